/* src/bei_pkg.sv */
// shared types and constants for the breakpoint envelope interpolator
package bei_pkg;

	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = 7;
	localparam int QueueDepth = 2;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic        func;
		logic [5:0]  entry_index;
		logic [31:0] point_time;
		logic signed [31:0] point_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [5:0]  span_index;
	} out_item_t;

	typedef struct packed {
		logic            func;
		logic [IdxW-1:0] entry_index;
		logic [31:0]     query_time;
		logic [31:0]     point_value;
		logic [CntW-1:0] count;
	} query_t;

endpackage

/* src/bei_ram.sv */
// generic single write port, single read port ram with registered read
module bei_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* src/bei_front.sv */
// front end: accepts items and queues them in order for the back end
module bei_front import bei_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  in_item_t       item,
	input  logic [CntW-1:0] count,
	output logic           busy,
	output logic           q_valid,
	output query_t         q_head,
	input  logic           q_pop
);
	query_t                 fifo_q [QueueDepth];
	logic [0:0]             wptr_q, rptr_q;
	logic [1:0]             fill_q;
	logic                   acc, push;
	logic [CntW-1:0]        cnt_eff;

	assign busy = (fill_q == 2'(QueueDepth));
	assign acc = start && !busy;
	assign push = acc;
	assign q_valid = fill_q != 2'd0;
	assign q_head = fifo_q[rptr_q];

	always_comb begin
		cnt_eff = count;
		if (count == '0) begin
			cnt_eff = CntW'(1);
		end else if (count > CntW'(TableDepth)) begin
			cnt_eff = CntW'(TableDepth);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{func: item.func, entry_index: item.entry_index,
				query_time: item.point_time, point_value: item.point_value,
				count: cnt_eff};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (q_pop) rptr_q <= rptr_q + 1'b1;
			fill_q <= fill_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

/* src/bei_back.sv */
// back end: performs table writes, scans the table and interpolates one query at a time
module bei_back import bei_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  query_t          q_head,
	output logic            q_pop,
	output logic            tbl_we,
	output logic [IdxW-1:0] tbl_waddr,
	output logic [31:0]     tbl_time,
	output logic [31:0]     tbl_value,
	output logic [IdxW-1:0] raddr,
	input  logic [31:0]     rd_time,
	input  logic [31:0]     rd_value,
	output logic            res_valid,
	output out_item_t       res
);
	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_LEFT, S_DIV, S_MUL, S_ADD
	} state_t;

	state_t            state_q;
	logic [31:0]       t_q;
	logic [CntW-1:0]   n_q;
	logic [CntW-1:0]   i_q;
	logic              wait_q;
	logic [31:0]       tr_q, tl_q;
	logic signed [31:0] vr_q, vl_q;
	logic [32:0]       rem_q;
	logic [15:0]       frac_q;
	logic [3:0]        bit_q;
	logic signed [49:0] prod_q;
	logic [31:0]       width_w;
	logic [33:0]       trial;
	logic signed [63:0] sum_w;

	assign width_w = tr_q - tl_q;
	assign trial = {rem_q, 1'b0} - {2'b0, width_w};
	assign sum_w = 64'(vl_q) + 64'(prod_q >>> 16);

	assign tbl_we = state_q == S_IDLE && q_valid && !q_pop && q_head.func == FUNC_WRITE;
	assign tbl_waddr = q_head.entry_index;
	assign tbl_time = q_head.query_time;
	assign tbl_value = q_head.point_value;

	always_comb begin
		raddr = i_q[IdxW-1:0];
		if (state_q == S_IDLE) raddr = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			q_pop <= 1'b0;
			res_valid <= 1'b0;
			i_q <= '0;
			wait_q <= 1'b0;
		end else begin
			q_pop <= 1'b0;
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && !q_pop) begin
						q_pop <= 1'b1;
						if (q_head.func == FUNC_QUERY) begin
							t_q <= q_head.query_time;
							n_q <= q_head.count;
							i_q <= '0;
							wait_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else if (t_q <= rd_time || i_q + 1'b1 == n_q) begin
						tr_q <= rd_time;
						vr_q <= rd_value;
						if (i_q == '0 || t_q > rd_time) begin
							res.value_out <= rd_value;
							res.span_index <= i_q[5:0];
							res_valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q - 1'b1;
							wait_q <= 1'b1;
							state_q <= S_LEFT;
						end
					end else begin
						i_q <= i_q + 1'b1;
						wait_q <= 1'b1;
					end
				end
				S_LEFT: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						tl_q <= rd_time;
						vl_q <= rd_value;
						i_q <= i_q + 1'b1;
						if (tr_q <= rd_time || t_q == tr_q) begin
							res.value_out <= vr_q;
							res.span_index <= 6'(i_q + 1'b1);
							res_valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							rem_q <= {1'b0, t_q - rd_time};
							bit_q <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (!trial[33]) begin
						rem_q <= trial[32:0];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[31:0], 1'b0};
						frac_q <= {frac_q[14:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
					if (bit_q == 4'd15) state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= (50'(vr_q) - 50'(vl_q)) * $signed({1'b0, frac_q});
					state_q <= S_ADD;
				end
				S_ADD: begin
					res.value_out <= sum_w[31:0];
					res.span_index <= i_q[5:0];
					res_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/breakpoint_envelope_interpolator_top.sv */
// top level of the breakpoint envelope interpolator
// Items pass in order through a two-item queue; busy is high only when it is full.
// A write item is taken from the queue head into the table; a query scans the table one
// entry at a time (one registered ram read each), then reads the left point and, when it
// interpolates, runs 16 division steps, a multiply and an add.
// Results appear for one cycle on done and cannot be held off.
module breakpoint_envelope_interpolator_top import bei_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  in_item_t        in_item,
	output logic            done,
	output out_item_t       out_item,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CntW-1:0] cfg_data
);
	logic [CntW-1:0] count_q;
	logic            tbl_we, q_valid, q_pop;
	logic [IdxW-1:0] waddr, raddr;
	logic [31:0]     wtime, wvalue, rtime, rvalue;
	query_t          q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CntW'(1);
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	bei_front u_front (
		.clk, .arst_n, .start, .item(in_item), .count(count_q), .busy,
		.q_valid, .q_head, .q_pop
	);

	bei_ram #(.Width(32), .Depth(TableDepth)) u_time_ram (
		.clk, .we(tbl_we), .waddr, .wdata(wtime), .raddr, .rdata(rtime)
	);

	bei_ram #(.Width(32), .Depth(TableDepth)) u_value_ram (
		.clk, .we(tbl_we), .waddr, .wdata(wvalue), .raddr, .rdata(rvalue)
	);

	bei_back u_back (
		.clk, .arst_n, .q_valid, .q_head, .q_pop,
		.tbl_we, .tbl_waddr(waddr), .tbl_time(wtime), .tbl_value(wvalue), .raddr,
		.rd_time(rtime), .rd_value(rvalue), .res_valid(done), .res(out_item)
	);

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> $past(q_valid)) else $error("pop from empty queue");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");
	a_no_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !done) else $error("pop while result shown");
endmodule

/* verif/breakpoint_envelope_interpolator_top_test.sv */
// testbench for the breakpoint envelope interpolator: directed and random items, scoreboard check
module breakpoint_envelope_interpolator_top_test;
	import bei_pkg::*;

	class envelope_scoreboard;
		logic [31:0] time_tbl[TableDepth];
		logic signed [31:0] value_tbl[TableDepth];
		logic [CntW-1:0] point_count = 1;
		out_item_t expected_q[$];
		int errors = 0;

		function int used_points();
			int n;
			n = point_count;
			if (n == 0) n = 1;
			if (n > TableDepth) n = TableDepth;
			return n;
		endfunction

		function out_item_t interpolate(logic [31:0] t);
			out_item_t r;
			int n, i;
			longint unsigned tl, tr, frac;
			longint vl, vr, prod;
			n = used_points();
			for (i = 0; i < n; i++) begin
				if (t <= time_tbl[i]) break;
			end
			if (i == 0) begin
				r.value_out = value_tbl[0];
				r.span_index = 0;
			end else if (i == n) begin
				r.value_out = value_tbl[n-1];
				r.span_index = 6'(n - 1);
			end else begin
				tl = time_tbl[i-1];
				tr = time_tbl[i];
				r.span_index = 6'(i);
				if (tr <= tl || t == tr) begin
					r.value_out = value_tbl[i];
				end else begin
					frac = ((longint'(t) - tl) << 16) / (tr - tl);
					vl = value_tbl[i-1];
					vr = value_tbl[i];
					prod = (vr - vl) * longint'(frac);
					r.value_out = 32'(vl + (prod >>> 16));
				end
			end
			return r;
		endfunction

		function void note_item(in_item_t it);
			if (it.func == FUNC_WRITE) begin
				time_tbl[it.entry_index] = it.point_time;
				value_tbl[it.entry_index] = it.point_value;
			end else begin
				expected_q.push_back(interpolate(it.point_time));
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected: value %h span %0d", $time,
					got.value_out, got.span_index);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.value_out !== exp_r.value_out) begin
				$display("%0t: value_out expected %h actual %h", $time,
					exp_r.value_out, got.value_out);
				errors++;
			end
			if (got.span_index !== exp_r.span_index) begin
				$display("%0t: span_index expected %0d actual %0d", $time,
					exp_r.span_index, got.span_index);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	in_item_t in_item = '0;
	logic done;
	out_item_t out_item;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CntW-1:0] cfg_data = '0;
	bit calm = 0;
	envelope_scoreboard sb = new();

	breakpoint_envelope_interpolator_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .out_item(out_item), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_item(in_item);
		if (arst_n && done) sb.check_result(out_item);
	end

	task automatic send_item(in_item_t it);
		if (!calm && $urandom_range(0, 99) < 15) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1;
		in_item <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_point(int idx, logic [31:0] t, logic [31:0] v);
		in_item_t it;
		it.func = FUNC_WRITE;
		it.entry_index = 6'(idx);
		it.point_time = t;
		it.point_value = v;
		send_item(it);
	endtask

	task automatic query_at(logic [31:0] t);
		in_item_t it;
		it.func = FUNC_QUERY;
		it.entry_index = 6'($urandom);
		it.point_time = t;
		it.point_value = $urandom;
		send_item(it);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_count(logic [CntW-1:0] cnt);
		drain();
		cfg_valid <= 1;
		cfg_data <= cnt;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		sb.point_count = cnt;
	endtask

	task automatic random_phase(logic [CntW-1:0] cnt, int nitems, bit wide);
		int n, k, r;
		logic [31:0] t, lo, hi;
		set_count(cnt);
		n = sb.used_points();
		t = wide ? $urandom_range(0, 32'h0100_0000) : $urandom_range(0, 32'h0000_4000);
		for (k = 0; k < n; k++) begin
			write_point(k, t, $urandom);
			if ($urandom_range(0, 9) != 0)
				t = t + (wide ? $urandom_range(1, 32'h0300_0000) : $urandom_range(1, 32'h8000));
		end
		for (k = 0; k < nitems; k++) begin
			r = $urandom_range(0, 99);
			lo = sb.time_tbl[0];
			hi = sb.time_tbl[n-1];
			if (r < 8)
				write_point($urandom_range(0, n - 1), $urandom, $urandom);
			else if (r < 20)
				query_at(sb.time_tbl[$urandom_range(0, n - 1)]);
			else if (r < 30)
				query_at($urandom);
			else if (hi > lo)
				query_at(lo - 32'($urandom_range(0, 50)) + ($urandom % (hi - lo + 100)));
			else
				query_at(lo + 32'($urandom_range(0, 20)) - 10);
		end
	endtask

	initial begin
		#100000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed table: zero-width span, unsorted entry, extremes
		set_count(8);
		write_point(0, 32'h0000_0100, 32'h8000_0000);
		write_point(1, 32'h0000_0100, 32'h7fff_ffff);
		write_point(2, 32'h0001_0000, 32'hffff_fffb);
		write_point(3, 32'h0003_0000, 32'h0001_2345);
		write_point(4, 32'h0002_0000, 32'h0000_0000);
		write_point(5, 32'h8000_0000, 32'h7fff_ffff);
		write_point(6, 32'hffff_fffe, 32'h8000_0000);
		write_point(7, 32'hffff_ffff, 32'h0000_0001);
		query_at(32'h0000_0000);
		query_at(32'h0000_0100);
		query_at(32'h0000_0200);
		query_at(32'h0000_ffff);
		query_at(32'h0003_0000);
		query_at(32'h0002_8000);
		query_at(32'h0002_0001);
		query_at(32'h4000_0000);
		query_at(32'hffff_fffe);
		query_at(32'hffff_ffff);
		set_count(7);
		query_at(32'hffff_ffff);
		query_at(32'hffff_fffd);
		random_phase(0, 120, 0);
		random_phase(64, 180, 1);
		random_phase(3, 130, 0);
		calm = 1;
		random_phase(127, 180, 1);
		calm = 0;
		random_phase(1, 100, 1);
		random_phase(20, 160, 0);
		random_phase(64, 160, 0);
		random_phase(5, 120, 1);
		drain();
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* filelist.f */
src/bei_pkg.sv
src/bei_ram.sv
src/bei_front.sv
src/bei_back.sv
src/breakpoint_envelope_interpolator_top.sv
verif/breakpoint_envelope_interpolator_top_test.sv
